// ===== sv/rcm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the RCM ordering block.
package rcm_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 8192;

   localparam int NODE_W = $clog2(MAX_NODES);        // node index
   localparam int CNT_W  = $clog2(MAX_NODES + 1);    // node count
   localparam int EADR_W = $clog2(MAX_EDGES);        // edge store address
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);    // edge count, list start and length
   localparam int KEY_W  = 11;
   localparam int STEP_W = 5;

   // Item actions
   localparam logic [1:0] ACT_BEGIN  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_OVF   = 2'd2;

   // Controller steps
   localparam logic [STEP_W-1:0] ST_CLEAR = 5'd0;   // zero the order store after reset
   localparam logic [STEP_W-1:0] ST_IDLE  = 5'd1;
   localparam logic [STEP_W-1:0] ST_MCLR  = 5'd2;   // clear visit marks
   localparam logic [STEP_W-1:0] ST_SI    = 5'd3;   // sort: next node
   localparam logic [STEP_W-1:0] ST_SK    = 5'd4;   // sort: latch its key
   localparam logic [STEP_W-1:0] ST_SJ    = 5'd5;   // sort: probe slot below
   localparam logic [STEP_W-1:0] ST_SW1   = 5'd6;   // sort: fetch probed key
   localparam logic [STEP_W-1:0] ST_SW2   = 5'd7;   // sort: shift or insert
   localparam logic [STEP_W-1:0] ST_WTOP  = 5'd8;   // walk: loop head
   localparam logic [STEP_W-1:0] ST_SCAN  = 5'd9;   // walk: fetch candidate
   localparam logic [STEP_W-1:0] ST_SC1   = 5'd10;  // walk: fetch candidate mark
   localparam logic [STEP_W-1:0] ST_SC2   = 5'd11;  // walk: skip or seed component
   localparam logic [STEP_W-1:0] ST_EXP   = 5'd12;  // walk: fetch node to expand
   localparam logic [STEP_W-1:0] ST_EX1   = 5'd13;  // walk: fetch its list bounds
   localparam logic [STEP_W-1:0] ST_EX2   = 5'd14;  // walk: latch list bounds
   localparam logic [STEP_W-1:0] ST_NB    = 5'd15;  // walk: fetch neighbor
   localparam logic [STEP_W-1:0] ST_NB1   = 5'd16;  // walk: fetch neighbor mark
   localparam logic [STEP_W-1:0] ST_NB2   = 5'd17;  // walk: number neighbor

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              accept;
   } cmd_type;

   typedef struct packed {
      logic nodes_zero;
      logic clr_last;
      logic mclr_last;
      logic sort_done;
      logic j_zero;
      logic key_gt;
      logic scan_end;
      logic scan_last;
      logic done_eq_placed;
      logic mark_set;
      logic cur_out;
      logic list_end;
      logic nb_out;
   } stat_type;

endpackage

// ===== sv/rcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rcm_ctrl.sv =====
// Step sequencer for loading, sorting and the breadth-first walk.
module rcm_ctrl import rcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_action,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   logic [STEP_W-1:0] state_ff, state_in;

   // next step
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start && req_action == ACT_RUN && !stat.nodes_zero) state_in = ST_MCLR;
         end
         ST_MCLR: if (stat.mclr_last) state_in = ST_SI;
         ST_SI:   state_in = stat.sort_done ? ST_WTOP : ST_SK;
         ST_SK:   state_in = ST_SJ;
         ST_SJ:   state_in = stat.j_zero ? ST_SI : ST_SW1;
         ST_SW1:  state_in = ST_SW2;
         ST_SW2:  state_in = stat.key_gt ? ST_SJ : ST_SI;
         ST_WTOP: begin
            if (stat.scan_end) state_in = ST_IDLE;
            else if (stat.done_eq_placed) state_in = ST_SCAN;
            else state_in = ST_EXP;
         end
         ST_SCAN: state_in = ST_SC1;
         ST_SC1:  state_in = ST_SC2;
         ST_SC2: begin
            if (!stat.mark_set) state_in = ST_EXP;
            else if (stat.scan_last) state_in = ST_IDLE;
            else state_in = ST_SCAN;
         end
         ST_EXP:  state_in = ST_EX1;
         ST_EX1:  state_in = stat.cur_out ? ST_WTOP : ST_EX2;
         ST_EX2:  state_in = ST_NB;
         ST_NB:   state_in = stat.list_end ? ST_WTOP : ST_NB1;
         ST_NB1:  state_in = stat.nb_out ? ST_NB : ST_NB2;
         ST_NB2:  state_in = ST_NB;
         default: state_in = ST_IDLE;
      endcase
   end

   // hold step
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.step   = state_ff;
   assign cmd.accept = start && (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == ST_CLEAR)
      else $error("clearing pass not entered after reset");
   a_sort_to_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SI && stat.sort_done) |=> state_ff == ST_WTOP)
      else $error("sort finished but walk not started");
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_action == ACT_RUN && !stat.nodes_zero)
      |=> state_ff == ST_MCLR)
      else $error("run item did not start the mark clear");
`endif

endmodule

// ===== sv/rcm_dpath.sv =====
// Stores, counters and address selection for loading, sorting, walking and reads.
module rcm_dpath import rcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [1:0]        req_action,
   input  logic [KEY_W-1:0]  req_sort_key,
   input  logic [NODE_W-1:0] req_neighbor,
   input  logic [NODE_W-1:0] req_position,
   output stat_type          stat,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [NODE_W-1:0] rsp_node,
   output logic [CNT_W-1:0]  rsp_node_count
);

   // load bookkeeping
   logic [CNT_W-1:0]  nodes_ff, nodes_in;
   logic [ECNT_W-1:0] edges_ff, edges_in;
   logic              ovf_ff, ovf_in;
   logic [ECNT_W-1:0] cur_len_ff, cur_len_in;
   logic [NODE_W-1:0] clr_ff, clr_in;

   // run registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [KEY_W-1:0]  kv_ff, kv_in;
   logic [NODE_W-1:0] t_ff, t_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  placed_ff, placed_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [NODE_W-1:0] cand_ff, cand_in;
   logic [ECNT_W-1:0] base_ff, base_in;
   logic [ECNT_W-1:0] len_ff, len_in;
   logic [ECNT_W-1:0] jj_ff, jj_in;
   logic [NODE_W-1:0] nb_ff, nb_in;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // memory ports
   logic              key_we, start_we, len_we, edge_we, sort_we, mark_we, order_we;
   logic [NODE_W-1:0] key_wa, key_ra, load_wa, len_wa, sort_wa, sort_ra;
   logic [NODE_W-1:0] mark_wa, mark_ra, order_wa, order_ra;
   logic [ECNT_W-1:0] len_wd;
   logic [NODE_W-1:0] sort_wd, order_wd;
   logic              mark_wd;
   logic [KEY_W-1:0]  key_rd;
   logic [ECNT_W-1:0] start_rd, len_rd;
   logic [NODE_W-1:0] edge_rd, sort_rd, order_rd;
   logic              mark_rd;

   logic [ECNT_W:0]   edge_pos;
   logic [NODE_W-1:0] place_addr;
   logic              is_begin, is_append, is_read;

   assign is_begin  = cmd.accept && req_action == ACT_BEGIN;
   assign is_append = cmd.accept && req_action == ACT_APPEND;
   assign is_read   = cmd.accept && req_action == ACT_READ;

   assign edge_pos   = {1'b0, base_ff} + {1'b0, jj_ff};
   assign place_addr = NODE_W'(count_ff - CNT_W'(1) - placed_ff);
   assign load_wa    = nodes_ff[NODE_W-1:0];

   // status toward the sequencer
   assign stat.nodes_zero     = (nodes_ff == '0);
   assign stat.clr_last       = (clr_ff == NODE_W'(MAX_NODES - 1));
   assign stat.mclr_last      = (i_ff == count_ff - CNT_W'(1));
   assign stat.sort_done      = (i_ff == count_ff);
   assign stat.j_zero         = (j_ff == '0);
   assign stat.key_gt         = (key_rd > kv_ff);
   assign stat.scan_end       = (scan_ff >= count_ff);
   assign stat.scan_last      = (scan_ff + CNT_W'(1) >= count_ff);
   assign stat.done_eq_placed = (done_ff == placed_ff);
   assign stat.mark_set       = mark_rd;
   assign stat.cur_out        = ({1'b0, order_rd} >= count_ff);
   assign stat.list_end       = (jj_ff == len_ff) || (edge_pos >= (ECNT_W+1)'(MAX_EDGES));
   assign stat.nb_out         = ({1'b0, edge_rd} >= count_ff);

   // register updates per step
   always_comb begin
      nodes_in      = nodes_ff;
      edges_in      = edges_ff;
      ovf_in        = ovf_ff;
      cur_len_in    = cur_len_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      kv_in         = kv_ff;
      t_in          = t_ff;
      scan_in       = scan_ff;
      placed_in     = placed_ff;
      done_in       = done_ff;
      cand_in       = cand_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      jj_in         = jj_ff;
      nb_in         = nb_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (cmd.step)
         ST_CLEAR: clr_in = clr_ff + NODE_W'(1);
         ST_IDLE: begin
            if (is_begin) begin
               if (nodes_ff >= CNT_W'(MAX_NODES)) begin
                  ovf_in = 1'b1;
               end else begin
                  nodes_in   = nodes_ff + CNT_W'(1);
                  cur_len_in = '0;
               end
            end
            if (is_append && !stat.nodes_zero) begin
               if (edges_ff >= ECNT_W'(MAX_EDGES)) begin
                  ovf_in = 1'b1;
               end else begin
                  edges_in   = edges_ff + ECNT_W'(1);
                  cur_len_in = cur_len_ff + ECNT_W'(1);
               end
            end
            if (is_read) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = nodes_ff;
               if ({1'b0, req_position} >= nodes_ff) rsp_status_in = STAT_RANGE;
               else if (ovf_ff) rsp_status_in = STAT_OVF;
               else rsp_status_in = STAT_OK;
            end
            count_in = nodes_ff;
            i_in     = '0;
         end
         ST_MCLR: i_in = stat.mclr_last ? '0 : i_ff + CNT_W'(1);
         ST_SI: begin
            j_in      = i_ff;
            scan_in   = '0;
            placed_in = '0;
            done_in   = '0;
         end
         ST_SK: kv_in = key_rd;
         ST_SJ: if (stat.j_zero) i_in = i_ff + CNT_W'(1);
         ST_SW1: t_in = sort_rd;
         ST_SW2: begin
            if (stat.key_gt) j_in = j_ff - CNT_W'(1);
            else i_in = i_ff + CNT_W'(1);
         end
         ST_SC1: cand_in = sort_rd;
         ST_SC2: begin
            scan_in = scan_ff + CNT_W'(1);
            if (!mark_rd) placed_in = placed_ff + CNT_W'(1);
         end
         ST_EXP: done_in = done_ff + CNT_W'(1);
         ST_EX2: begin
            base_in = start_rd;
            len_in  = len_rd;
            jj_in   = '0;
         end
         ST_NB1: begin
            nb_in = edge_rd;
            if (stat.nb_out) jj_in = jj_ff + ECNT_W'(1);
         end
         ST_NB2: begin
            jj_in = jj_ff + ECNT_W'(1);
            if (!mark_rd) placed_in = placed_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff     <= '0;
         edges_ff     <= '0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nodes_ff     <= nodes_in;
         edges_ff     <= edges_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_len_ff    <= cur_len_in;
      count_ff      <= count_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      kv_ff         <= kv_in;
      t_ff          <= t_in;
      scan_ff       <= scan_in;
      placed_ff     <= placed_in;
      done_ff       <= done_in;
      cand_ff       <= cand_in;
      base_ff       <= base_in;
      len_ff        <= len_in;
      jj_ff         <= jj_in;
      nb_ff         <= nb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // memory write and read address selection
   always_comb begin
      key_we   = is_begin && nodes_ff < CNT_W'(MAX_NODES);
      start_we = key_we;
      key_wa   = load_wa;
      len_we   = key_we;
      len_wa   = load_wa;
      len_wd   = '0;
      if (is_append && !stat.nodes_zero && edges_ff < ECNT_W'(MAX_EDGES)) begin
         len_we = 1'b1;
         len_wa = NODE_W'(nodes_ff - CNT_W'(1));
         len_wd = cur_len_ff + ECNT_W'(1);
      end
      edge_we = is_append && !stat.nodes_zero && edges_ff < ECNT_W'(MAX_EDGES);

      sort_we = (cmd.step == ST_SJ && stat.j_zero) || cmd.step == ST_SW2;
      sort_wa = j_ff[NODE_W-1:0];
      sort_wd = (cmd.step == ST_SW2 && stat.key_gt) ? t_ff : i_ff[NODE_W-1:0];

      mark_we = cmd.step == ST_MCLR
                || ((cmd.step == ST_SC2 || cmd.step == ST_NB2) && !mark_rd);
      mark_wd = (cmd.step != ST_MCLR);
      case (cmd.step)
         ST_SC2:  mark_wa = cand_ff;
         ST_NB2:  mark_wa = nb_ff;
         default: mark_wa = i_ff[NODE_W-1:0];
      endcase

      order_we = cmd.step == ST_CLEAR
                 || ((cmd.step == ST_SC2 || cmd.step == ST_NB2) && !mark_rd);
      order_wa = (cmd.step == ST_CLEAR) ? clr_ff : place_addr;
      case (cmd.step)
         ST_SC2:  order_wd = cand_ff;
         ST_NB2:  order_wd = nb_ff;
         default: order_wd = '0;
      endcase

      key_ra   = (cmd.step == ST_SW1) ? sort_rd : i_ff[NODE_W-1:0];
      sort_ra  = (cmd.step == ST_SCAN) ? scan_ff[NODE_W-1:0]
                                       : NODE_W'(j_ff - CNT_W'(1));
      mark_ra  = (cmd.step == ST_NB1) ? edge_rd : sort_rd;
      order_ra = (cmd.step == ST_EXP) ? NODE_W'(count_ff - CNT_W'(1) - done_ff)
                                      : req_position;
   end

   rcm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_NODES)) u_key (
      .clock(clock), .we(key_we), .waddr(key_wa), .wdata(req_sort_key),
      .raddr(key_ra), .rdata(key_rd));

   rcm_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_start (
      .clock(clock), .we(start_we), .waddr(load_wa), .wdata(edges_ff),
      .raddr(order_rd), .rdata(start_rd));

   rcm_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_len (
      .clock(clock), .we(len_we), .waddr(len_wa), .wdata(len_wd),
      .raddr(order_rd), .rdata(len_rd));

   rcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edges_ff[EADR_W-1:0]), .wdata(req_neighbor),
      .raddr(edge_pos[EADR_W-1:0]), .rdata(edge_rd));

   rcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_sort (
      .clock(clock), .we(sort_we), .waddr(sort_wa), .wdata(sort_wd),
      .raddr(sort_ra), .rdata(sort_rd));

   rcm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
      .clock(clock), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
      .raddr(mark_ra), .rdata(mark_rd));

   rcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order (
      .clock(clock), .we(order_we), .waddr(order_wa), .wdata(order_wd),
      .raddr(order_ra), .rdata(order_rd));

   // drive result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node       = (rsp_status_ff == STAT_RANGE) ? '0 : order_rd;
   assign rsp_node_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(is_read))
      else $error("result without a read item");
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == ST_WTOP) |-> (done_ff <= placed_ff && placed_ff <= count_ff))
      else $error("walk counters out of order");
   a_edges_cap: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");
`endif

endmodule

// ===== sv/reverse_cuthill_mckee_order.sv =====
// Reverse Cuthill-McKee ordering: sequencer plus datapath with node, edge and order stores.
// Begin, append and read items are taken in the idle step without raising busy; a read strobes
// rsp_valid the next cycle. A run holds busy for the mark clear, an insertion sort by key
// (each node, each shift and the final insert), then the walk: each component seed, each skipped
// candidate, each other node expanded and each neighbor checked; results never stall.
// Synchronous reset; afterwards busy stays high while the order store clears.
module reverse_cuthill_mckee_order import rcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [KEY_W-1:0]  req_sort_key,
   input  logic [NODE_W-1:0] req_neighbor,
   input  logic [NODE_W-1:0] req_position,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [NODE_W-1:0] rsp_node,
   output logic [CNT_W-1:0]  rsp_node_count
);

   cmd_type  cmd;
   stat_type stat;

   rcm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .stat(stat), .cmd(cmd), .busy(busy));

   rcm_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .req_action(req_action),
      .req_sort_key(req_sort_key), .req_neighbor(req_neighbor),
      .req_position(req_position), .stat(stat), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_node(rsp_node), .rsp_node_count(rsp_node_count));

endmodule

// ===== test/tb_top.sv =====
// Testbench for the reverse Cuthill-McKee ordering block: directed table, random graph, overflow.
module tb_top;
   import rcm_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_ITEMS = 750;

   typedef struct packed {
      logic [1:0]        status;
      logic [NODE_W-1:0] node;
      logic [CNT_W-1:0]  count;
   } read_reply_type;

   typedef struct packed {
      logic [1:0]        act;
      logic [KEY_W-1:0]  key;
      logic [NODE_W-1:0] nb;
      logic [NODE_W-1:0] pos;
      bit                typed;
      read_reply_type    reply;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_action;
   logic [KEY_W-1:0]  req_sort_key;
   logic [NODE_W-1:0] req_neighbor;
   logic [NODE_W-1:0] req_position;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [NODE_W-1:0] rsp_node;
   logic [CNT_W-1:0]  rsp_node_count;

   reverse_cuthill_mckee_order u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_sort_key(req_sort_key),
      .req_neighbor(req_neighbor), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_node(rsp_node),
      .rsp_node_count(rsp_node_count)
   );

   // Shadow graph and ordering
   logic [KEY_W-1:0]  key_mem   [MAX_NODES];
   int unsigned       start_mem [MAX_NODES];
   int unsigned       len_mem   [MAX_NODES];
   logic [NODE_W-1:0] edge_mem  [MAX_EDGES];
   int unsigned       sorted_mem[MAX_NODES];
   bit                mark_mem  [MAX_NODES];
   logic [NODE_W-1:0] order_mem [MAX_NODES];
   int unsigned       node_total;
   int unsigned       edge_total;
   bit                ovf_seen;

   read_reply_type pending_replies[$];
   int             error_count = 0;
   int             cycle_count = 0;
   bit             calm;
   int unsigned    key_floor;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sort by key, then breadth-first walk filling the order from its far end
   function automatic void order_graph();
      int unsigned cnt, scan, placed, done, cur, v, j, e;
      logic [NODE_W-1:0] nbr;
      cnt = node_total;
      scan = 0;
      placed = 0;
      done = 0;
      if (cnt == 0) return;
      for (int unsigned i = 0; i < cnt; i++) begin
         v = i;
         j = i;
         while (j > 0 && key_mem[sorted_mem[j-1]] > key_mem[v]) begin
            sorted_mem[j] = sorted_mem[j-1];
            j--;
         end
         sorted_mem[j] = v;
      end
      for (int i = 0; i < MAX_NODES; i++) mark_mem[i] = 1'b0;
      while (scan < cnt) begin
         if (done == placed) begin
            while (scan < cnt && mark_mem[sorted_mem[scan]]) scan++;
            if (scan == cnt) break;
            cur = sorted_mem[scan];
            scan++;
            order_mem[cnt-1-placed] = cur[NODE_W-1:0];
            placed++;
            mark_mem[cur] = 1'b1;
         end
         cur = 32'(order_mem[cnt-1-done]);
         done++;
         if (cur >= cnt) continue;
         for (j = 0; j < len_mem[cur]; j++) begin
            e = start_mem[cur] + j;
            if (e >= MAX_EDGES) break;
            nbr = edge_mem[e];
            if (nbr >= cnt || mark_mem[nbr]) continue;
            order_mem[cnt-1-placed] = nbr;
            placed++;
            mark_mem[nbr] = 1'b1;
         end
      end
   endfunction

   // Advance the shadow state by one accepted item
   function automatic bit predict_item(logic [1:0] act, logic [KEY_W-1:0] key,
                                       logic [NODE_W-1:0] nb, logic [NODE_W-1:0] pos,
                                       output read_reply_type r);
      r = '0;
      case (act)
         ACT_BEGIN: begin
            if (node_total >= MAX_NODES) ovf_seen = 1'b1;
            else begin
               key_mem[node_total] = key;
               start_mem[node_total] = edge_total;
               len_mem[node_total] = 0;
               node_total++;
            end
            return 1'b0;
         end
         ACT_APPEND: begin
            if (node_total == 0) return 1'b0;
            if (edge_total >= MAX_EDGES) begin
               ovf_seen = 1'b1;
               return 1'b0;
            end
            edge_mem[edge_total] = nb;
            edge_total++;
            len_mem[node_total-1]++;
            return 1'b0;
         end
         ACT_RUN: begin
            order_graph();
            return 1'b0;
         end
         default: begin
            if (pos >= node_total) r.status = STAT_RANGE;
            else begin
               r.node = order_mem[pos];
               r.status = ovf_seen ? STAT_OVF : STAT_OK;
            end
            r.count = node_total[CNT_W-1:0];
            return 1'b1;
         end
      endcase
   endfunction

   // Offer one item, hold it until accepted, then log what it should return
   task automatic issue_item(logic [1:0] act, logic [KEY_W-1:0] key, logic [NODE_W-1:0] nb,
                             logic [NODE_W-1:0] pos, bit typed, read_reply_type typed_reply);
      read_reply_type r;
      bit             has_reply;
      if (!calm) begin
         while ($urandom_range(0, 99) < 31) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_action <= act;
      req_sort_key <= key;
      req_neighbor <= nb;
      req_position <= pos;
      do @(posedge clock); while (busy);
      has_reply = predict_item(act, key, nb, pos, r);
      if (has_reply) pending_replies.push_back(typed ? typed_reply : r);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      read_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) report_mismatch("result with nothing expected");
         else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_node !== want.node)
               report_mismatch($sformatf("node %0d want %0d", rsp_node, want.node));
            if (rsp_node_count !== want.count)
               report_mismatch($sformatf("node_count %0d want %0d", rsp_node_count, want.count));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Keys rise slowly so the sort stays cheap, with ties and rare outliers
   function automatic logic [KEY_W-1:0] next_key();
      int unsigned k;
      if ($urandom_range(0, 99) == 0) k = $urandom_range(0, 1024);
      else begin
         k = key_floor + $urandom_range(0, 4);
         key_floor = key_floor + $urandom_range(0, 3);
      end
      if (k > 1024) k = 1024;
      if (key_floor > 1024) key_floor = 1024;
      return k[KEY_W-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] pick_neighbor();
      int unsigned top;
      top = node_total + 2;
      if (top > 1023) top = 1023;
      if ($urandom_range(0, 99) < 75) return NODE_W'($urandom_range(0, top));
      return NODE_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [NODE_W-1:0] pick_position();
      int unsigned top;
      top = (node_total == 0) ? 0 : node_total - 1;
      if (top > 1023) top = 1023;
      if ($urandom_range(0, 99) < 85) return NODE_W'($urandom_range(0, top));
      return NODE_W'($urandom_range(0, 1023));
   endfunction

   stim_row_type directed_rows[22] = '{
      '{ACT_READ,   11'd0,    10'd0,    10'd0,    1'b1, '{STAT_RANGE, 10'd0, 11'd0}},
      '{ACT_READ,   11'd0,    10'd0,    10'd1023, 1'b1, '{STAT_RANGE, 10'd0, 11'd0}},
      '{ACT_APPEND, 11'd0,    10'd3,    10'd0,    1'b0, '0},
      '{ACT_RUN,    11'd0,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd0,    1'b1, '{STAT_RANGE, 10'd0, 11'd0}},
      '{ACT_BEGIN,  11'd1024, 10'd0,    10'd0,    1'b0, '0},
      '{ACT_APPEND, 11'd0,    10'd1,    10'd0,    1'b0, '0},
      '{ACT_BEGIN,  11'd0,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_APPEND, 11'd0,    10'd1023, 10'd0,    1'b0, '0},
      '{ACT_APPEND, 11'd0,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_BEGIN,  11'd1023, 10'd0,    10'd0,    1'b0, '0},
      '{ACT_BEGIN,  11'd5,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_APPEND, 11'd0,    10'd2,    10'd0,    1'b0, '0},
      '{ACT_BEGIN,  11'd5,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd0,    1'b1, '{STAT_OK, 10'd0, 11'd5}},
      '{ACT_READ,   11'd0,    10'd0,    10'd5,    1'b1, '{STAT_RANGE, 10'd0, 11'd5}},
      '{ACT_RUN,    11'd0,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd4,    1'b0, '0},
      '{ACT_BEGIN,  11'd2,    10'd0,    10'd0,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd5,    1'b0, '0},
      '{ACT_READ,   11'd0,    10'd0,    10'd1023, 1'b1, '{STAT_RANGE, 10'd0, 11'd6}}
   };

   initial begin
      int unsigned pick;
      for (int i = 0; i < MAX_NODES; i++) begin
         order_mem[i] = '0;
         mark_mem[i] = 1'b0;
      end
      node_total = 0;
      edge_total = 0;
      ovf_seen = 1'b0;
      calm = 1'b0;
      key_floor = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_BEGIN;
      req_sort_key <= '0;
      req_neighbor <= '0;
      req_position <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i])
         issue_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].nb,
                    directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].reply);

      // Random graph growth with runs and reads mixed in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 400 && n < 600);
         if (n == 700) begin
            start <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 65 && node_total < 900)
            issue_item(ACT_BEGIN, next_key(), NODE_W'($urandom_range(0, 1023)),
                       NODE_W'($urandom_range(0, 1023)), 1'b0, '0);
         else if (pick < 85)
            issue_item(ACT_APPEND, KEY_W'($urandom_range(0, 2047)), pick_neighbor(),
                       NODE_W'($urandom_range(0, 1023)), 1'b0, '0);
         else if (pick < 87)
            issue_item(ACT_RUN, KEY_W'($urandom_range(0, 2047)),
                       NODE_W'($urandom_range(0, 1023)),
                       NODE_W'($urandom_range(0, 1023)), 1'b0, '0);
         else
            issue_item(ACT_READ, KEY_W'($urandom_range(0, 2047)),
                       NODE_W'($urandom_range(0, 1023)), pick_position(), 1'b0, '0);
      end
      calm = 1'b0;

      // Fill the node store, then overflow it
      while (node_total < MAX_NODES)
         issue_item(ACT_BEGIN, next_key(), '0, '0, 1'b0, '0);
      issue_item(ACT_READ, '0, '0, 10'd1023, 1'b0, '0);
      issue_item(ACT_BEGIN, 11'd7, '0, '0, 1'b0, '0);
      issue_item(ACT_APPEND, '0, 10'd9, '0, 1'b0, '0);
      issue_item(ACT_APPEND, '0, 10'd1023, '0, 1'b0, '0);
      issue_item(ACT_RUN, '0, '0, '0, 1'b0, '0);
      repeat (40) issue_item(ACT_READ, '0, '0, NODE_W'($urandom_range(0, 1023)), 1'b0, '0);
      issue_item(ACT_READ, '0, '0, 10'd1023, 1'b0, '0);
      issue_item(ACT_READ, '0, '0, 10'd0, 1'b0, '0);
      start <= 1'b0;

      // Drain
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
